>>> rtl/tmcw_pkg.sv
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared types and constants for the text-mode console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tmcw_pkg;

  // Input field widths
  localparam int unsigned KIND_W = 3;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ADDR_FIELD_W = 11;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned CELL_W = ATTR_W + CHAR_W;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_PRINT     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TYPED     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BACKSPACE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_COMMIT    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ      = 3'd5;

  // Character and attribute constants
  localparam logic [CHAR_W-1:0] NEWLINE    = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK      = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

  // Command queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_EMIT,
    OP_BACKSPACE,
    OP_CLEAR,
    OP_READ,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic [CHAR_W-1:0]       ch;
    logic                    newline;
    logic                    typed;
    logic                    commit;
    logic [ADDR_FIELD_W-1:0] addr;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/tmcw_ram.sv
// ----------------------------------------------------------------------------
// tmcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tmcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/tmcw_fifo.sv
// ----------------------------------------------------------------------------
// tmcw_fifo
// Short command queue that decouples the decoder from the executor.
// ----------------------------------------------------------------------------
`default_nettype none

module tmcw_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  valid_o
);

  localparam int unsigned DEPTH = tmcw_pkg::QUEUE_DEPTH;
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [NW-1:0]    count_q, count_d;

  assign full_o  = (count_q == NW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NW'(DEPTH))
    else $error("queue occupancy above depth");
`endif

endmodule

`default_nettype wire

>>> rtl/tmcw_front.sv
// ----------------------------------------------------------------------------
// tmcw_front
// Input handshake and item decode into queue commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tmcw_front (
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [tmcw_pkg::KIND_W-1:0]           kind_i,
  input  wire logic [tmcw_pkg::CHAR_W-1:0]           char_code_i,
  input  wire logic [tmcw_pkg::ADDR_FIELD_W-1:0]     read_address_i,
  input  wire logic                                  busy_i,
  input  wire logic                                  q_full_i,
  output logic                                       push_o,
  output tmcw_pkg::cmd_t                             cmd_o
);

  // No transactions while the store is being initialized.
  assign in_ready_o = !q_full_i && !busy_i;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.ch      = char_code_i;
    cmd_o.addr    = read_address_i;
    cmd_o.typed   = (kind_i == tmcw_pkg::KIND_TYPED);
    cmd_o.commit  = (kind_i == tmcw_pkg::KIND_COMMIT);
    cmd_o.newline = (kind_i == tmcw_pkg::KIND_COMMIT) ||
                    (char_code_i == tmcw_pkg::NEWLINE);
    unique case (kind_i)
      tmcw_pkg::KIND_PRINT,
      tmcw_pkg::KIND_TYPED,
      tmcw_pkg::KIND_COMMIT:    cmd_o.op = tmcw_pkg::OP_EMIT;
      tmcw_pkg::KIND_BACKSPACE: cmd_o.op = tmcw_pkg::OP_BACKSPACE;
      tmcw_pkg::KIND_CLEAR:     cmd_o.op = tmcw_pkg::OP_CLEAR;
      tmcw_pkg::KIND_READ:      cmd_o.op = tmcw_pkg::OP_READ;
      default:                  cmd_o.op = tmcw_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/tmcw_back.sv
// ----------------------------------------------------------------------------
// tmcw_back
// Command executor: cursor, pending count, text store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tmcw_back #(
  parameter int unsigned COLUMNS     = 80,
  parameter int unsigned ROWS        = 25,
  parameter int unsigned PENDING_MAX = 2047
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic [tmcw_pkg::ATTR_W-1:0]           attr_i,
  input  wire logic                                  cmd_valid_i,
  input  tmcw_pkg::cmd_t                             cmd_i,
  output logic                                       cmd_pop_o,
  output logic                                       busy_o,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic [tmcw_pkg::ADDR_FIELD_W-1:0]          cursor_position_o,
  output logic [tmcw_pkg::CELL_W-1:0]                cell_value_o,
  output logic                                       scrolled_o
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW  = $clog2(CELLS);
  localparam int unsigned CNW = $clog2(CELLS + 1);
  localparam int unsigned RW  = $clog2(ROWS);
  localparam int unsigned CW  = $clog2(COLUMNS);
  localparam int unsigned PNW = $clog2(PENDING_MAX + 1);
  localparam int unsigned FW  = tmcw_pkg::ADDR_FIELD_W;
  localparam int unsigned WW  = (AW > FW) ? AW : FW;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL
  } state_e;

  state_e                      state_q, state_d;
  logic [RW-1:0]               row_q, row_d;
  logic [CW-1:0]               col_q, col_d;
  logic [PNW-1:0]              pend_q, pend_d;
  logic [CNW-1:0]              cnt_q, cnt_d;
  logic                        fill_scr_q, fill_scr_d;
  logic                        out_valid_q, out_valid_d;
  logic [tmcw_pkg::CELL_W-1:0] out_cell_q, out_cell_d;
  logic                        out_scr_q, out_scr_d;

  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [tmcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

  logic [WW-1:0]  pos_w, addr_w;
  logic [AW-1:0]  cur_pos, bsp_pos;
  logic [CNW-1:0] scroll_src;
  logic [RW-1:0]  bsp_row;
  logic [CW-1:0]  bsp_col;
  logic           emit_adv;

  tmcw_ram #(
    .WIDTH (tmcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Cursor state only moves while no result is held, so the reported
  // position comes straight from it.
  assign pos_w   = WW'(row_q) * WW'(COLUMNS) + WW'(col_q);
  assign cur_pos = pos_w[AW-1:0];
  assign addr_w  = WW'(cmd_i.addr);

  // Backspace target cell
  always_comb begin
    bsp_row = row_q;
    bsp_col = col_q - 1'b1;
    if (col_q == '0) begin
      bsp_col = '0;
      if (row_q != '0) begin
        bsp_row = row_q - 1'b1;
        bsp_col = CW'(COLUMNS - 1);
      end
    end
  end
  assign bsp_pos = AW'(bsp_row) * AW'(COLUMNS) + AW'(bsp_col);

  // Copy pipeline: each cell is written in the cycle after it is read.
  assign scroll_src = cnt_q - CNW'(COLUMNS) - 1'b1;
  assign emit_adv   = cmd_i.newline || (col_q == CW'(COLUMNS - 1));

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    pend_d      = pend_q;
    cnt_d       = cnt_q;
    fill_scr_d  = fill_scr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_cell_d  = out_cell_q;
    out_scr_d   = out_scr_q;
    cmd_pop_o   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = cur_pos;
    ram_wdata   = {attr_i, cmd_i.ch};
    ram_re      = 1'b0;
    ram_raddr   = cnt_q[AW-1:0];

    unique case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[AW-1:0];
        ram_wdata = {tmcw_pkg::RESET_ATTR, tmcw_pkg::BLANK};
        if (cnt_q == CNW'(CELLS - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (cmd_valid_i && !out_valid_q) begin
          cmd_pop_o  = 1'b1;
          out_cell_d = '0;
          out_scr_d  = 1'b0;
          unique case (cmd_i.op)
            tmcw_pkg::OP_EMIT: begin
              ram_we = !cmd_i.newline;
              if (cmd_i.typed && (pend_q != PNW'(PENDING_MAX))) begin
                pend_d = pend_q + 1'b1;
              end
              if (cmd_i.commit) begin
                pend_d = '0;
              end
              if (emit_adv) begin
                col_d = '0;
                if (row_q == RW'(ROWS - 1)) begin
                  cnt_d   = CNW'(COLUMNS);
                  state_d = ST_SCROLL;
                end else begin
                  row_d       = row_q + 1'b1;
                  out_valid_d = 1'b1;
                end
              end else begin
                col_d       = col_q + 1'b1;
                out_valid_d = 1'b1;
              end
            end
            tmcw_pkg::OP_BACKSPACE: begin
              if (pend_q != '0) begin
                pend_d    = pend_q - 1'b1;
                row_d     = bsp_row;
                col_d     = bsp_col;
                ram_we    = 1'b1;
                ram_waddr = bsp_pos;
                ram_wdata = {attr_i, tmcw_pkg::BLANK};
              end
              out_valid_d = 1'b1;
            end
            tmcw_pkg::OP_CLEAR: begin
              pend_d     = '0;
              row_d      = '0;
              col_d      = '0;
              cnt_d      = '0;
              fill_scr_d = 1'b0;
              state_d    = ST_FILL;
            end
            tmcw_pkg::OP_READ: begin
              if (addr_w < WW'(CELLS)) begin
                ram_re    = 1'b1;
                ram_raddr = addr_w[AW-1:0];
                state_d   = ST_READ;
              end else begin
                out_valid_d = 1'b1;
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end

      ST_READ: begin
        out_cell_d  = ram_rdata;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end

      ST_SCROLL: begin
        ram_re    = (cnt_q != CNW'(CELLS));
        ram_raddr = cnt_q[AW-1:0];
        ram_we    = (cnt_q != CNW'(COLUMNS));
        ram_waddr = scroll_src[AW-1:0];
        ram_wdata = ram_rdata;
        if (cnt_q == CNW'(CELLS)) begin
          cnt_d      = CNW'(CELLS - COLUMNS);
          fill_scr_d = 1'b1;
          state_d    = ST_FILL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[AW-1:0];
        ram_wdata = {attr_i, tmcw_pkg::BLANK};
        if (cnt_q == CNW'(CELLS - 1)) begin
          out_cell_d  = '0;
          out_scr_d   = fill_scr_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      row_q       <= '0;
      col_q       <= '0;
      pend_q      <= '0;
      cnt_q       <= '0;
      fill_scr_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      fill_scr_q  <= fill_scr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_cell_q <= out_cell_d;
    out_scr_q  <= out_scr_d;
  end

  assign busy_o            = (state_q == ST_INIT);
  assign out_valid_o       = out_valid_q;
  assign cell_value_o      = out_cell_q;
  assign scrolled_o        = out_scr_q;
  assign cursor_position_o = pos_w[FW-1:0];

`ifndef ASSERT_OFF
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q < RW'(ROWS - 1)) || (row_q == RW'(ROWS - 1)))
    else $error("cursor row out of range");

  a_pend_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PNW'(PENDING_MAX))
    else $error("pending count above its limit");

  a_scroll_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_scr_q) |-> (row_q == RW'(ROWS - 1)) && (col_q == '0))
    else $error("scroll result without cursor on last row start");

  a_no_result_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |-> !out_valid_q && !cmd_pop_o)
    else $error("activity during store initialization");
`endif

endmodule

`default_nettype wire

>>> rtl/text_mode_console_writer.sv
// Each accepted command is queued, then executed by the back, which registers
//   its result; a cell read also passes through the store's registered read.
// A clear blanks every cell; a scroll copies rows up one cell per cycle (single
//   write port) and blanks the last row. The back waits out its result.
// Reset: the store's ROWS*COLUMNS cells (2000 by default) are swept to blank
//   with in_ready_o low; the attribute register resets to 0x0F.
// ----------------------------------------------------------------------------
// text_mode_console_writer
// Text console store with cursor, scroll, backspace and cell read-back.
// ----------------------------------------------------------------------------
`default_nettype none

module text_mode_console_writer #(
  parameter int unsigned COLUMNS     = 80,
  parameter int unsigned ROWS        = 25,
  parameter int unsigned PENDING_MAX = 2047
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // Attribute register write
  input  wire logic                                  cfg_we_i,
  input  wire logic [tmcw_pkg::ATTR_W-1:0]           cfg_data_i,
  // Input transaction
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [tmcw_pkg::KIND_W-1:0]           kind_i,
  input  wire logic [tmcw_pkg::CHAR_W-1:0]           char_code_i,
  input  wire logic [tmcw_pkg::ADDR_FIELD_W-1:0]     read_address_i,
  // Result transaction
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic [tmcw_pkg::ADDR_FIELD_W-1:0]          cursor_position_o,
  output logic [tmcw_pkg::CELL_W-1:0]                cell_value_o,
  output logic                                       scrolled_o
);

  // Attribute byte applied to every new cell written after reset (scroll copies
  // keep theirs). Only the reset sweep uses the fixed blank attribute.
  logic [tmcw_pkg::ATTR_W-1:0] attr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tmcw_pkg::RESET_ATTR;
    end else if (cfg_we_i) begin
      attr_q <= cfg_data_i;
    end
  end

  // Front: decode each transaction into a command and queue it.
  tmcw_pkg::cmd_t front_cmd, back_cmd;
  logic           push, q_full, q_valid, pop, busy;

  tmcw_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .char_code_i    (char_code_i),
    .read_address_i (read_address_i),
    .busy_i         (busy),
    .q_full_i       (q_full),
    .push_o         (push),
    .cmd_o          (front_cmd)
  );

  // Queue lets the front keep accepting while the back scrolls, clears or stalls.
  tmcw_fifo #(
    .WIDTH ($bits(tmcw_pkg::cmd_t))
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (back_cmd),
    .valid_o (q_valid)
  );

  // Back: executes one command at a time against the text store and holds
  // the result until the sink takes it.
  tmcw_back #(
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS),
    .PENDING_MAX (PENDING_MAX)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .attr_i            (attr_q),
    .cmd_valid_i       (q_valid),
    .cmd_i             (back_cmd),
    .cmd_pop_o         (pop),
    .busy_o            (busy),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .cursor_position_o (cursor_position_o),
    .cell_value_o      (cell_value_o),
    .scrolled_o        (scrolled_o)
  );

endmodule

`default_nettype wire

>>> sim/text_mode_console_writer_test.sv
// ----------------------------------------------------------------------------
// text_mode_console_writer_test
// Self-checking bench for the text console writer. A shadow copy of the
// screen, cursor and typed-character count predicts the status of every
// command; results are checked in order, field by field, under several
// attribute settings and handshake pacing modes.
// ----------------------------------------------------------------------------
`default_nettype none

module text_mode_console_writer_test;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int PENDING_MAX = 2047;
  localparam int CELLS       = COLUMNS * ROWS;

  // Kinds the block has no use for; they must leave everything untouched
  localparam logic [tmcw_pkg::KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [tmcw_pkg::KIND_W-1:0] KIND_SPARE_7 = 3'd7;

  // Watchdog limit, well above the slowest legal run (every command a clear or a
  // scroll, full stalls).
  localparam int unsigned LIMIT_CYCLES = 5_000_000;
  // A clear followed by a scroll is the longest the block can stay busy
  localparam int DRAIN_CYCLES = 2 * CELLS + 8;

  typedef struct {
    logic [tmcw_pkg::ADDR_FIELD_W-1:0] pos;
    logic [tmcw_pkg::CELL_W-1:0]       value;
    logic                              scrolled;
  } status_t;

  // --------------------------------------------------------------------------
  // Shadow console: mirrors the screen and cursor, queues the status each
  // accepted command should produce and checks returned statuses in order.
  // --------------------------------------------------------------------------
  class console_mirror;
    logic [tmcw_pkg::CELL_W-1:0] screen [CELLS];
    int                          row;
    int                          col;
    int                          typed_pending;
    logic [tmcw_pkg::ATTR_W-1:0] attr;
    status_t                     status_q [$];
    int                          errors;
    int                          checked;
    int                          scrolls;
    int                          clears;

    function new();
      for (int i = 0; i < CELLS; i++) screen[i] = {tmcw_pkg::RESET_ATTR, tmcw_pkg::BLANK};
      row           = 0;
      col           = 0;
      typed_pending = 0;
      attr          = tmcw_pkg::RESET_ATTR;
      errors        = 0;
      checked       = 0;
      scrolls       = 0;
      clears        = 0;
    endfunction

    function void set_attr(logic [tmcw_pkg::ATTR_W-1:0] v);
      attr = v;
    endfunction

    function int cursor_index();
      return row * COLUMNS + col;
    endfunction

    // Writes one character (or moves on for a newline); returns 1 on scroll
    function logic place_char(logic [tmcw_pkg::CHAR_W-1:0] ch);
      if (ch == tmcw_pkg::NEWLINE) begin
        col = 0;
        row++;
      end else begin
        screen[row * COLUMNS + col] = {attr, ch};
        col++;
        if (col == COLUMNS) begin
          col = 0;
          row++;
        end
      end
      if (row >= ROWS) begin
        for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {attr, tmcw_pkg::BLANK};
        row = ROWS - 1;
        scrolls++;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void apply_command(logic [tmcw_pkg::KIND_W-1:0] k,
                                logic [tmcw_pkg::CHAR_W-1:0] ch,
                                logic [tmcw_pkg::ADDR_FIELD_W-1:0] a);
      status_t s;
      s.value    = '0;
      s.scrolled = 1'b0;
      case (k)
        tmcw_pkg::KIND_PRINT: s.scrolled = place_char(ch);
        tmcw_pkg::KIND_TYPED: begin
          s.scrolled = place_char(ch);
          if (typed_pending < PENDING_MAX) typed_pending++;
        end
        tmcw_pkg::KIND_BACKSPACE: begin
          // only typed characters can be taken back
          if (typed_pending > 0) begin
            typed_pending--;
            if (col == 0) begin
              if (row > 0) begin
                row--;
                col = COLUMNS - 1;
              end
            end else begin
              col--;
            end
            screen[row * COLUMNS + col] = {attr, tmcw_pkg::BLANK};
          end
        end
        tmcw_pkg::KIND_CLEAR: begin
          for (int i = 0; i < CELLS; i++) screen[i] = {attr, tmcw_pkg::BLANK};
          row           = 0;
          col           = 0;
          typed_pending = 0;
          clears++;
        end
        tmcw_pkg::KIND_COMMIT: begin
          s.scrolled    = place_char(tmcw_pkg::NEWLINE);
          typed_pending = 0;
        end
        tmcw_pkg::KIND_READ: begin
          if (a < CELLS) s.value = screen[a];
        end
        default: ;
      endcase
      s.pos = tmcw_pkg::ADDR_FIELD_W'(row * COLUMNS + col);
      status_q = {status_q, s};
    endfunction

    function void check_status(logic [tmcw_pkg::ADDR_FIELD_W-1:0] pos,
                               logic [tmcw_pkg::CELL_W-1:0] value,
                               logic scrolled);
      status_t s;
      if (status_q.size() == 0) begin
        $error("status with no command outstanding: cursor_position %0d", pos);
        errors++;
        return;
      end
      s = status_q.pop_front();
      checked++;
      if (pos !== s.pos) begin
        $error("cursor_position: expected %0d, actual %0d", s.pos, pos);
        errors++;
      end
      if (value !== s.value) begin
        $error("cell_value: expected 0x%04h, actual 0x%04h", s.value, value);
        errors++;
      end
      if (scrolled !== s.scrolled) begin
        $error("scrolled: expected %0b, actual %0b", s.scrolled, scrolled);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT hookup. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                              clk       = 1'b0;
  logic                              rst_n     = 1'b0;
  logic                              cfg_we    = 1'b0;
  logic [tmcw_pkg::ATTR_W-1:0]       cfg_data  = '0;
  logic                              in_valid  = 1'b0;
  logic                              in_ready;
  logic [tmcw_pkg::KIND_W-1:0]       kind      = '0;
  logic [tmcw_pkg::CHAR_W-1:0]       char_code = '0;
  logic [tmcw_pkg::ADDR_FIELD_W-1:0] read_addr = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [tmcw_pkg::ADDR_FIELD_W-1:0] cursor_pos;
  logic [tmcw_pkg::CELL_W-1:0]       cell_value;
  logic                              scrolled;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  text_mode_console_writer #(
    .COLUMNS    (COLUMNS),
    .ROWS       (ROWS),
    .PENDING_MAX(PENDING_MAX)
  ) i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .kind_i           (kind),
    .char_code_i      (char_code),
    .read_address_i   (read_addr),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .cursor_position_o(cursor_pos),
    .cell_value_o     (cell_value),
    .scrolled_o       (scrolled)
  );

  console_mirror mirror = new();

  // Pacing knobs, percent of cycles spent idle on each side
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cmds_sent      = 0;
  int directed_cmds  = 0;

  int unsigned cycle_count = 0;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: a transaction completes on an edge where valid and the
  // ready we drove last cycle are both high. Ready is redrawn every cycle
  // so stalls land on any point of the block's work.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready)
      mirror.check_status(cursor_pos, cell_value, scrolled);
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------

  // Offers one command, honoring the sender idle rate; valid stays high
  // into the next command when no gap is drawn.
  task automatic put_cmd(input logic [tmcw_pkg::KIND_W-1:0] k,
                         input logic [tmcw_pkg::CHAR_W-1:0] ch,
                         input logic [tmcw_pkg::ADDR_FIELD_W-1:0] a);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    char_code <= ch;
    read_addr <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mirror.apply_command(k, ch, a);
    cmds_sent++;
  endtask

  // Drops valid, waits for every status, then applies the new setting.
  // Nothing is in flight once the last status is back, since every command
  // answers exactly once.
  task automatic next_phase(input logic write_attr,
                            input logic [tmcw_pkg::ATTR_W-1:0] attr,
                            input int sidle, input int rstall);
    in_valid <= 1'b0;
    @(posedge clk);
    while (mirror.status_q.size() != 0) @(posedge clk);
    recv_stall_pct = rstall;
    send_idle_pct  = sidle;
    if (write_attr) begin
      cfg_we   <= 1'b1;
      cfg_data <= attr;
      @(posedge clk);
      cfg_we <= 1'b0;
      mirror.set_attr(attr);
    end
  endtask

  // Mostly printable text, some spaces, now and then any byte at all
  function automatic logic [tmcw_pkg::CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(9);
    if (r < 8) return tmcw_pkg::CHAR_W'($urandom_range(8'h7E, 8'h21));
    if (r == 8) return tmcw_pkg::BLANK;
    return tmcw_pkg::CHAR_W'($urandom_range(255));
  endfunction

  // Reads favor cells just behind the cursor, where text was last written
  function automatic logic [tmcw_pkg::ADDR_FIELD_W-1:0] pick_addr();
    int r;
    int p;
    r = $urandom_range(9);
    if (r < 5) begin
      p = mirror.cursor_index() - int'($urandom_range(100));
      return tmcw_pkg::ADDR_FIELD_W'(p < 0 ? 0 : p);
    end
    if (r < 8) return tmcw_pkg::ADDR_FIELD_W'($urandom_range(CELLS - 1));
    if (r == 8) return tmcw_pkg::ADDR_FIELD_W'($urandom_range(2047));
    case ($urandom_range(3))
      0:       return '0;
      1:       return tmcw_pkg::ADDR_FIELD_W'(CELLS - 1);
      2:       return tmcw_pkg::ADDR_FIELD_W'(CELLS);
      default: return '1;
    endcase
  endfunction

  function automatic logic [tmcw_pkg::ADDR_FIELD_W-1:0] any_addr();
    return tmcw_pkg::ADDR_FIELD_W'($urandom_range(2047));
  endfunction

  task automatic put_line_end();
    case ($urandom_range(2))
      0:       put_cmd(tmcw_pkg::KIND_COMMIT, pick_char(), any_addr());
      1:       put_cmd(tmcw_pkg::KIND_PRINT, tmcw_pkg::NEWLINE, any_addr());
      default: put_cmd(tmcw_pkg::KIND_TYPED, tmcw_pkg::NEWLINE, any_addr());
    endcase
  endtask

  // Random traffic made of console-like bursts: lines of text, typed lines
  // with corrections, runs of newlines to reach the bottom and scroll,
  // read-backs, clears, and some raw noise.
  task automatic random_traffic(input int n);
    int                          start;
    int                          pick;
    int                          len;
    int                          bs;
    logic [tmcw_pkg::KIND_W-1:0] k;
    start = cmds_sent;
    while (cmds_sent - start < n) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(100, 60) : $urandom_range(12);
        k   = $urandom_range(1) ? tmcw_pkg::KIND_PRINT : tmcw_pkg::KIND_TYPED;
        for (int i = 0; i < len; i++) put_cmd(k, pick_char(), any_addr());
        put_line_end();
      end else if (pick < 55) begin
        // typed line, some corrections (possibly more than typed), maybe commit
        len = ($urandom_range(7) == 0) ? $urandom_range(95, 70) : $urandom_range(20, 1);
        for (int i = 0; i < len; i++) put_cmd(tmcw_pkg::KIND_TYPED, pick_char(), any_addr());
        bs = $urandom_range(len + 2);
        for (int i = 0; i < bs; i++)
          put_cmd(tmcw_pkg::KIND_BACKSPACE, pick_char(), any_addr());
        len = $urandom_range(5);
        for (int i = 0; i < len; i++) put_cmd(tmcw_pkg::KIND_TYPED, pick_char(), any_addr());
        if ($urandom_range(1)) put_cmd(tmcw_pkg::KIND_COMMIT, pick_char(), any_addr());
      end else if (pick < 67) begin
        len = $urandom_range(8, 2);
        for (int i = 0; i < len; i++) put_line_end();
      end else if (pick < 82) begin
        len = $urandom_range(5, 1);
        for (int i = 0; i < len; i++) put_cmd(tmcw_pkg::KIND_READ, pick_char(), pick_addr());
      end else if (pick < 85) begin
        put_cmd(tmcw_pkg::KIND_CLEAR, pick_char(), any_addr());
      end else begin
        len = $urandom_range(4, 1);
        for (int i = 0; i < len; i++)
          put_cmd(tmcw_pkg::KIND_W'($urandom_range(7)),
                  tmcw_pkg::CHAR_W'($urandom_range(255)), any_addr());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset contents, field extremes, every kind, corner cases.
    // The first accept waits out the post-reset clearing sweep.
    next_phase(1'b0, '0, 0, 0);
    put_cmd(tmcw_pkg::KIND_READ, 8'h00, 11'd0);                // blank after reset
    put_cmd(tmcw_pkg::KIND_READ, 8'hFF, tmcw_pkg::ADDR_FIELD_W'(CELLS - 1));
    put_cmd(tmcw_pkg::KIND_READ, 8'h00, tmcw_pkg::ADDR_FIELD_W'(CELLS)); // just off the end
    put_cmd(tmcw_pkg::KIND_READ, 8'h00, '1);                   // far off the end
    put_cmd(tmcw_pkg::KIND_PRINT, 8'h00, '0);
    put_cmd(tmcw_pkg::KIND_PRINT, 8'hFF, '1);
    put_cmd(tmcw_pkg::KIND_TYPED, 8'h41, '0);
    put_cmd(tmcw_pkg::KIND_BACKSPACE, 8'h00, '0);              // erases the typed 'A'
    put_cmd(tmcw_pkg::KIND_BACKSPACE, 8'h00, '0);              // nothing left to erase
    put_cmd(tmcw_pkg::KIND_READ, 8'h00, 11'd2);
    put_cmd(tmcw_pkg::KIND_TYPED, tmcw_pkg::NEWLINE, '0);      // typed newline still counts
    put_cmd(tmcw_pkg::KIND_BACKSPACE, 8'h00, '0);              // column 0: back to end of row 0
    put_cmd(tmcw_pkg::KIND_READ, 8'h00, tmcw_pkg::ADDR_FIELD_W'(COLUMNS - 1));
    put_cmd(KIND_SPARE_6, 8'hFF, '1);
    put_cmd(KIND_SPARE_7, 8'hAA, 11'h555);
    put_cmd(tmcw_pkg::KIND_COMMIT, 8'h00, '0);
    put_cmd(tmcw_pkg::KIND_BACKSPACE, 8'h00, '0);              // commit dropped the pending count
    put_cmd(tmcw_pkg::KIND_PRINT, tmcw_pkg::NEWLINE, '0);
    put_cmd(tmcw_pkg::KIND_PRINT, 8'h7E, '0);
    put_cmd(tmcw_pkg::KIND_READ, 8'h00, tmcw_pkg::ADDR_FIELD_W'(2 * COLUMNS));
    put_cmd(tmcw_pkg::KIND_CLEAR, 8'h00, '0);
    put_cmd(tmcw_pkg::KIND_READ, 8'h00, tmcw_pkg::ADDR_FIELD_W'(2 * COLUMNS));
    directed_cmds = cmds_sent;

    // Random traffic over the pacing modes and attribute extremes
    next_phase(1'b1, 8'hFF, 0, 0);
    random_traffic(65);
    next_phase(1'b1, 8'h00, 62, 0);
    random_traffic(65);
    next_phase(1'b1, tmcw_pkg::ATTR_W'($urandom_range(254, 1)), 0, 62);
    random_traffic(65);
    next_phase(1'b1, 8'h5A, 26, 26);
    random_traffic(65);

    // Wait for the tail, then give a stray status time to show up
    next_phase(1'b0, '0, 0, 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.status_q.size() != 0) begin
      $error("%0d statuses never arrived", mirror.status_q.size());
      mirror.errors++;
    end

    $display("Ran %0d commands (%0d directed, then random console bursts",
             cmds_sent, directed_cmds);
    $display("  under four pacing modes): %0d statuses checked, %0d scrolls, %0d clears.",
             mirror.checked, mirror.scrolls, mirror.clears);
    if (mirror.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
